FILE: design/bspp_pkg.sv
// Shared types and constants for the boundary strength peak picker.
// Word layouts of the note, internal strength and decision channels.
// No dependencies.
`default_nettype none

package bspp_pkg;

    localparam int SPAN_DEFAULT = 4;

    localparam int STR_W     = 16;  // Q0.16 interval strength
    localparam int WGT_W     = 8;   // Q0.8 weight
    localparam int PROD_W    = STR_W + WGT_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CMB_W     = 17;  // combined strength
    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_IOI   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_REST  = 2'd2;

    localparam logic [WGT_W-1:0] WEIGHT_IOI_RST   = 8'd128;
    localparam logic [WGT_W-1:0] WEIGHT_PITCH_RST = 8'd64;
    localparam logic [WGT_W-1:0] WEIGHT_REST_RST  = 8'd64;

    typedef struct packed {
        logic [STR_W-1:0] ioi_strength;
        logic [STR_W-1:0] pitch_strength;
        logic [STR_W-1:0] rest_strength;
        logic             last_note;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [CMB_W-1:0] combined_strength;
        logic             is_boundary;
        logic             last_result;
    } out_word_t;

    typedef struct packed {
        logic [CMB_W-1:0] strength;
        logic             last_note;
    } cmb_word_t;

endpackage

`default_nettype wire

FILE: design/boundary_strength_peak_picker.sv
// Boundary strength peak picker: weighted note strengths, local maximum picking.
// Registers: combine word, then decision word; the decision for note n is formed
// when note n+SPAN enters the window, and flush words follow the final note.
// Throughput: one note per cycle unless m_ready stalls the output; the final
// note holds off input while its up to SPAN+1 words drain, one per cycle as m_ready allows.
// Reset: synchronous, active low; weights to defaults, window and position cleared.
`default_nettype none

module boundary_strength_peak_picker #(
    parameter int SPAN = bspp_pkg::SPAN_DEFAULT
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [bspp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [bspp_pkg::WGT_W-1:0]      cfg_data,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire bspp_pkg::in_word_t        s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output bspp_pkg::out_word_t            m_data
);

    logic                c_valid;
    logic                c_ready;
    bspp_pkg::cmb_word_t c_data;

    bspp_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .c_valid   (c_valid),
        .c_ready   (c_ready),
        .c_data    (c_data)
    );

    bspp_window #(
        .SPAN (SPAN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .c_valid (c_valid),
        .c_ready (c_ready),
        .c_data  (c_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: design/bspp_combine.sv
// Weight registers and weighted sum of the three interval strengths.
// Registers one combined strength word per note. Uses bspp_pkg.
`default_nettype none

module bspp_combine (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [bspp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [bspp_pkg::WGT_W-1:0]        cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire bspp_pkg::in_word_t          s_data,
    output logic                             c_valid,
    input  wire                              c_ready,
    output bspp_pkg::cmb_word_t              c_data
);

    logic [bspp_pkg::WGT_W-1:0]  w_ioi_reg;
    logic [bspp_pkg::WGT_W-1:0]  w_pitch_reg;
    logic [bspp_pkg::WGT_W-1:0]  w_rest_reg;
    logic [bspp_pkg::PROD_W-1:0] prod_ioi;
    logic [bspp_pkg::PROD_W-1:0] prod_pitch;
    logic [bspp_pkg::PROD_W-1:0] prod_rest;
    logic [bspp_pkg::SUM_W-1:0]  sum;
    logic                        c_valid_reg;
    bspp_pkg::cmb_word_t         c_word_reg;
    bspp_pkg::cmb_word_t         c_word_next;
    logic                        take;

    assign cfg_ready = 1'b1;
    assign s_ready   = !c_valid_reg || c_ready;
    assign take      = s_valid && s_ready;
    assign c_valid   = c_valid_reg;
    assign c_data    = c_word_reg;

    assign prod_ioi   = s_data.ioi_strength * w_ioi_reg;
    assign prod_pitch = s_data.pitch_strength * w_pitch_reg;
    assign prod_rest  = s_data.rest_strength * w_rest_reg;
    assign sum = bspp_pkg::SUM_W'(prod_ioi) + bspp_pkg::SUM_W'(prod_pitch)
               + bspp_pkg::SUM_W'(prod_rest);

    // halve and drop to Q1.16: floor(sum / 512)
    always_comb begin
        c_word_next.strength  = sum[bspp_pkg::SUM_W-1:9];
        c_word_next.last_note = s_data.last_note;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_ioi_reg   <= bspp_pkg::WEIGHT_IOI_RST;
            w_pitch_reg <= bspp_pkg::WEIGHT_PITCH_RST;
            w_rest_reg  <= bspp_pkg::WEIGHT_REST_RST;
            c_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    bspp_pkg::REG_WEIGHT_IOI:   w_ioi_reg   <= cfg_data;
                    bspp_pkg::REG_WEIGHT_PITCH: w_pitch_reg <= cfg_data;
                    bspp_pkg::REG_WEIGHT_REST:  w_rest_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_ready) begin
                c_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            c_word_reg <= c_word_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bspp_window.sv
// Sliding strength window, local maximum decision and end-of-part flush.
// Drives the registered decision word. Uses bspp_pkg.
`default_nettype none

module bspp_window #(
    parameter int SPAN = bspp_pkg::SPAN_DEFAULT
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      c_valid,
    output logic                     c_ready,
    input  wire bspp_pkg::cmb_word_t c_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output bspp_pkg::out_word_t      m_data
);

    localparam int WIN = 2 * SPAN + 1;
    localparam int KW  = $clog2(WIN);
    localparam int CW  = bspp_pkg::CMB_W;
    localparam int PW  = bspp_pkg::POS_W;

    logic [CW-1:0]  win_reg   [WIN];
    logic [CW-1:0]  win_shift [WIN];
    logic [CW-1:0]  src       [WIN];
    logic [WIN-1:0] vld_reg;
    logic [WIN-1:0] vld_shift;
    logic [WIN-1:0] srcv;
    logic           flush_reg;
    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  k_start;
    logic [KW-1:0]  kc;
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  fpos_reg;
    logic [PW-1:0]  fpos_next;
    logic           m_valid_reg;
    bspp_pkg::out_word_t m_word_reg;
    bspp_pkg::out_word_t m_word_next;
    logic [CW-1:0]  cand;
    logic           beaten;
    logic           out_free;
    logic           take;
    logic           flush_emit;
    logic           final_k;
    logic           out_load;

    assign out_free   = !m_valid_reg || m_ready;
    assign c_ready    = !flush_reg && out_free;
    assign take       = c_valid && c_ready;
    assign flush_emit = flush_reg && out_free;
    assign final_k    = flush_reg && (k_reg == KW'(WIN - 1));
    assign out_load   = (take && !c_data.last_note && vld_shift[SPAN]) || flush_emit;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_word_reg;

    // newest entry at the top
    always_comb begin
        for (int j = 0; j < WIN - 1; j++) begin
            win_shift[j] = win_reg[j+1];
        end
        win_shift[WIN-1] = c_data.strength;
        vld_shift = {1'b1, vld_reg[WIN-1:1]};
    end

    // first flushed entry: oldest valid one at or above the center
    always_comb begin
        k_start = KW'(WIN - 1);
        for (int j = WIN - 1; j >= SPAN; j--) begin
            if (vld_shift[j]) begin
                k_start = KW'(j);
            end
        end
        fpos_next = pos_reg - PW'(WIN - 1) + PW'(k_start);
    end

    // normal decisions use the center of the updated window,
    // flush decisions walk the frozen window
    always_comb begin
        kc = flush_reg ? k_reg : KW'(SPAN);
        for (int j = 0; j < WIN; j++) begin
            src[j]  = flush_reg ? win_reg[j] : win_shift[j];
            srcv[j] = flush_reg ? vld_reg[j] : vld_shift[j];
        end
        cand   = src[kc];
        beaten = 1'b0;
        for (int j = 0; j < WIN; j++) begin
            if (srcv[j] && (j != int'(kc)) && (j + SPAN >= int'(kc))
                    && (src[j] > cand)) begin
                beaten = 1'b1;
            end
        end
    end

    always_comb begin
        m_word_next.position          = flush_reg ? fpos_reg : pos_reg - PW'(SPAN);
        m_word_next.combined_strength = cand;
        m_word_next.is_boundary       = !final_k && !beaten;
        m_word_next.last_result       = final_k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            flush_reg   <= 1'b0;
            k_reg       <= '0;
            pos_reg     <= '0;
            fpos_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= out_load;
            end
            if (take) begin
                vld_reg <= vld_shift;
                if (c_data.last_note) begin
                    flush_reg <= 1'b1;
                    k_reg     <= k_start;
                    fpos_reg  <= fpos_next;
                end else begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
            if (flush_emit) begin
                if (final_k) begin
                    flush_reg <= 1'b0;
                    vld_reg   <= '0;
                    pos_reg   <= '0;
                end else begin
                    k_reg    <= k_reg + KW'(1);
                    fpos_reg <= fpos_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            win_reg <= win_shift;
        end
        if (out_load) begin
            m_word_reg <= m_word_next;
        end
    end

    a_last_not_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_word_reg.last_result |-> !m_word_reg.is_boundary)
        else $error("final decision flagged as boundary");

    a_flush_has_final: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> vld_reg[WIN-1])
        else $error("flush without final note in window");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_emit && final_k |=> (vld_reg == '0) && (pos_reg == '0) && !flush_reg)
        else $error("state not cleared after flush");

    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(flush_reg) |-> $past(take) && $past(c_data.last_note))
        else $error("flush entered without final note");

endmodule

`default_nettype wire
